// ===== sv/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// fps_pkg
// Shared widths, constants and types of the five-point stencil product core.
// ----------------------------------------------------------------------------
`default_nettype none

package fps_pkg;

    localparam int VAL_W        = 32;
    localparam int PROD_W       = 64;
    localparam int PAIR_W       = 65;
    localparam int SUM_W        = 67;
    localparam int FRAC_W       = 16;
    localparam int CFG_W        = 6;
    localparam int GRID_W_RESET = 32;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] diag;
        logic signed [VAL_W-1:0] west;
        logic signed [VAL_W-1:0] east;
        logic signed [VAL_W-1:0] south;
        logic signed [VAL_W-1:0] north;
    } t_fps_point;

    typedef struct packed {
        logic valid;
        logic west_en;
        logic east_en;
        logic south_en;
        logic north_en;
        logic last;
    } t_fps_issue;

    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] xw;
        logic signed [VAL_W-1:0] xe;
        logic signed [VAL_W-1:0] xs;
        logic signed [VAL_W-1:0] xn;
        logic signed [VAL_W-1:0] diag;
        logic signed [VAL_W-1:0] west;
        logic signed [VAL_W-1:0] east;
        logic signed [VAL_W-1:0] south;
        logic signed [VAL_W-1:0] north;
    } t_fps_ops;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    sat;
        logic                    last;
    } t_fps_result;

    typedef enum logic {
        ST_STREAM,
        ST_FLUSH
    } t_fps_state;

endpackage

`default_nettype wire

// ===== sv/fps_if.sv =====
// ----------------------------------------------------------------------------
// fps channel interfaces
// Point input, result output and grid width configuration channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface fps_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [fps_pkg::VAL_W-1:0] sample_value;
    logic signed [fps_pkg::VAL_W-1:0] diag_coef;
    logic signed [fps_pkg::VAL_W-1:0] west_coef;
    logic signed [fps_pkg::VAL_W-1:0] east_coef;
    logic signed [fps_pkg::VAL_W-1:0] south_coef;
    logic signed [fps_pkg::VAL_W-1:0] north_coef;

    modport source (
        output valid, sample_value, diag_coef, west_coef, east_coef, south_coef,
               north_coef,
        input  ready
    );
    modport sink (
        input  valid, sample_value, diag_coef, west_coef, east_coef, south_coef,
               north_coef,
        output ready
    );
endinterface

interface fps_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [fps_pkg::VAL_W-1:0] product_value;
    logic                             saturated;
    logic                             frame_last;

    modport source (output valid, product_value, saturated, frame_last, input ready);
    modport sink   (input valid, product_value, saturated, frame_last, output ready);
endinterface

interface fps_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [fps_pkg::CFG_W-1:0]  side_len;

    modport source (output valid, side_len, input ready);
    modport sink   (input valid, side_len, output ready);
endinterface

`default_nettype wire

// ===== sv/fps_cell.sv =====
// ----------------------------------------------------------------------------
// fps_cell
// One stage of the row delay line: loads from its neighbor, or from the head
// when it is the tail cell for the current grid width.
// ----------------------------------------------------------------------------
`default_nettype none

module fps_cell #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_shift,
    input  logic             i_tail,
    input  logic [WIDTH-1:0] i_next,
    input  logic [WIDTH-1:0] i_head,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_tail ? i_head : i_next;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== sv/fps_mac.sv =====
// ----------------------------------------------------------------------------
// fps_mac
// Five-term multiply and sum pipeline with round-half-up and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module fps_mac (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fps_pkg::t_fps_issue  i_issue,
    input  fps_pkg::t_fps_ops    i_ops,
    output logic                 o_ready,
    output logic                 o_valid,
    output fps_pkg::t_fps_result o_res,
    input  logic                 i_ready
);

    localparam int VAL_W  = fps_pkg::VAL_W;
    localparam int PROD_W = fps_pkg::PROD_W;
    localparam int PAIR_W = fps_pkg::PAIR_W;
    localparam int SUM_W  = fps_pkg::SUM_W;
    localparam int FRAC_W = fps_pkg::FRAC_W;

    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_o_v;
    logic adv1, adv2, adv3, adv4, adv_o;

    fps_pkg::t_fps_ops    n_s1_ops, r_s1_ops;
    logic                 r_s1_last, r_s2_last, r_s3_last, r_s4_last;
    logic signed [PROD_W-1:0] r_pd, r_pw, r_pe, r_ps, r_pn;
    logic signed [PAIR_W-1:0] r_t0, r_t1;
    logic signed [PROD_W-1:0] r_t2;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_rnd, n_shr;
    logic [SUM_W-VAL_W:0]     n_hi;
    logic                     n_in_range;
    fps_pkg::t_fps_result     n_res, r_o_res;

    assign adv_o = !r_o_v || i_ready;
    assign adv4  = !r_s4_v || adv_o;
    assign adv3  = !r_s3_v || adv4;
    assign adv2  = !r_s2_v || adv3;
    assign adv1  = !r_s1_v || adv2;
    assign o_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (adv1)  r_s1_v <= i_issue.valid;
            if (adv2)  r_s2_v <= r_s1_v;
            if (adv3)  r_s3_v <= r_s2_v;
            if (adv4)  r_s4_v <= r_s3_v;
            if (adv_o) r_o_v  <= r_s4_v;
        end
    end

    // off-grid neighbors contribute nothing; both factors are cleared
    always_comb begin
        n_s1_ops = i_ops;
        if (!i_issue.west_en) begin
            n_s1_ops.west = '0;
            n_s1_ops.xw   = '0;
        end
        if (!i_issue.east_en) begin
            n_s1_ops.east = '0;
            n_s1_ops.xe   = '0;
        end
        if (!i_issue.south_en) begin
            n_s1_ops.south = '0;
            n_s1_ops.xs    = '0;
        end
        if (!i_issue.north_en) begin
            n_s1_ops.north = '0;
            n_s1_ops.xn    = '0;
        end
    end

    always_comb begin
        n_rnd      = r_sum + fps_pkg::ROUND_HALF;
        n_shr      = n_rnd >>> FRAC_W;
        n_hi       = n_shr[SUM_W-1:VAL_W-1];
        n_in_range = (&n_hi) || !(|n_hi);
        n_res.value = n_in_range ? n_shr[VAL_W-1:0]
                    : (n_shr[SUM_W-1] ? fps_pkg::VAL_MIN : fps_pkg::VAL_MAX);
        n_res.sat   = !n_in_range;
        n_res.last  = r_s4_last;
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_ops  <= n_s1_ops;
            r_s1_last <= i_issue.last;
        end
        if (adv2) begin
            r_pd      <= PROD_W'(r_s1_ops.diag)  * PROD_W'(r_s1_ops.x);
            r_pw      <= PROD_W'(r_s1_ops.west)  * PROD_W'(r_s1_ops.xw);
            r_pe      <= PROD_W'(r_s1_ops.east)  * PROD_W'(r_s1_ops.xe);
            r_ps      <= PROD_W'(r_s1_ops.south) * PROD_W'(r_s1_ops.xs);
            r_pn      <= PROD_W'(r_s1_ops.north) * PROD_W'(r_s1_ops.xn);
            r_s2_last <= r_s1_last;
        end
        if (adv3) begin
            r_t0      <= PAIR_W'(r_pd) - PAIR_W'(r_pw);
            r_t1      <= PAIR_W'(r_pe) + PAIR_W'(r_ps);
            r_t2      <= r_pn;
            r_s3_last <= r_s2_last;
        end
        if (adv4) begin
            r_sum     <= SUM_W'(r_t0) - SUM_W'(r_t1) - SUM_W'(r_t2);
            r_s4_last <= r_s3_last;
        end
        if (adv_o) begin
            r_o_res   <= n_res;
        end
    end

    assign o_valid = r_o_v;
    assign o_res   = r_o_res;

`ifndef NO_ASSERTIONS
    ap_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_res.sat) |->
            (r_o_res.value == fps_pkg::VAL_MAX || r_o_res.value == fps_pkg::VAL_MIN))
        else $error("saturated beat without a limit value");
`endif

endmodule

`default_nettype wire

// ===== sv/five_point_stencil_apply_core.sv =====
// ----------------------------------------------------------------------------
// five_point_stencil_apply_core
// Streams a square grid in raster order and returns the five-point stencil
// product of every point, signed Q16.16, saturated and flagged.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | beat
//  i_in     | in  | sample_value, diag/west/east/south/north_coef   | one grid point
//  i_cfg    | in  | side_len                                        | width write
//  o_out    | out | product_value, saturated, frame_last            | one result
//
//  One point per cycle while o_out is not stalled. After the last point of a
//  frame the last row is drained from the cell chain, during which i_in.ready
//  is low. A result passes the fps_mac stage registers before it is on o_out.
//  i_rst_n (sync, active low) sets grid width to 32, capped at MAX_WIDTH.
//  Backpressure on o_out fills the pipeline stages before i_in.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module five_point_stencil_apply_core #(
    parameter int MAX_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fps_in_if.sink     i_in,
    fps_cfg_if.sink    i_cfg,
    fps_out_if.source  o_out
);

    localparam int VAL_W   = fps_pkg::VAL_W;
    localparam int CFG_W   = fps_pkg::CFG_W;
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int PW      = $bits(fps_pkg::t_fps_point);
    localparam int RESET_N = (fps_pkg::GRID_W_RESET > MAX_WIDTH) ? MAX_WIDTH
                           : fps_pkg::GRID_W_RESET;
    localparam logic [CW-1:0]    RESET_NM1 = CW'(RESET_N - 1);
    localparam logic [CW-1:0]    MAX_NM1   = CW'(MAX_WIDTH - 1);
    localparam logic [CFG_W-1:0] MAX_W_CFG = CFG_W'(MAX_WIDTH);

    fps_pkg::t_fps_state  r_state, n_state;
    logic [CW-1:0]        r_nm1, n_cfg_nm1;
    logic [CW-1:0]        r_col, n_col, r_row, n_row;
    logic signed [VAL_W-1:0] r_west;

    fps_pkg::t_fps_point     a_data [MAX_WIDTH];
    logic signed [VAL_W-1:0] b_data [MAX_WIDTH];
    fps_pkg::t_fps_point     in_pt;

    logic in_fire, cfg_fire, flush_step, shift, mac_ready, in_rdy, flushing;
    fps_pkg::t_fps_issue  issue;
    fps_pkg::t_fps_ops    ops;
    fps_pkg::t_fps_result res;
    logic                 res_valid;

    assign in_fire    = i_in.valid && i_in.ready;
    assign cfg_fire   = i_cfg.valid && i_cfg.ready;
    assign flush_step = flushing && mac_ready;
    assign shift      = in_fire || flush_step;
    assign i_in.ready = in_rdy;
    assign i_cfg.ready = 1'b1;

    assign in_pt.value = i_in.sample_value;
    assign in_pt.diag  = i_in.diag_coef;
    assign in_pt.west  = i_in.west_coef;
    assign in_pt.east  = i_in.east_coef;
    assign in_pt.south = i_in.south_coef;
    assign in_pt.north = i_in.north_coef;

    always_comb begin
        n_state = r_state;
        if (cfg_fire) begin
            n_state = fps_pkg::ST_STREAM;
        end else begin
            unique case (r_state)
                fps_pkg::ST_STREAM: begin
                    if (in_fire && r_col == r_nm1 && r_row == r_nm1) begin
                        n_state = fps_pkg::ST_FLUSH;
                    end
                end
                fps_pkg::ST_FLUSH: begin
                    if (flush_step && r_col == r_nm1) begin
                        n_state = fps_pkg::ST_STREAM;
                    end
                end
                default: n_state = fps_pkg::ST_STREAM;
            endcase
        end
    end

    always_comb begin
        unique case (r_state)
            fps_pkg::ST_STREAM: begin
                in_rdy   = mac_ready;
                flushing = 1'b0;
            end
            fps_pkg::ST_FLUSH: begin
                in_rdy   = 1'b0;
                flushing = 1'b1;
            end
            default: begin
                in_rdy   = 1'b0;
                flushing = 1'b0;
            end
        endcase
    end

    // during a drain r_col walks the last row
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        priority if (cfg_fire) begin
            n_col = '0;
            n_row = '0;
        end else if (in_fire) begin
            if (r_col == r_nm1) begin
                n_col = '0;
                n_row = (r_row == r_nm1) ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end else if (flush_step) begin
            n_col = (r_col == r_nm1) ? '0 : r_col + CW'(1);
        end else begin
            n_col = r_col;
        end
    end

    always_comb begin
        priority if (i_cfg.side_len == '0) begin
            n_cfg_nm1 = '0;
        end else if (i_cfg.side_len > MAX_W_CFG) begin
            n_cfg_nm1 = MAX_NM1;
        end else begin
            n_cfg_nm1 = CW'(i_cfg.side_len - CFG_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fps_pkg::ST_STREAM;
            r_nm1   <= RESET_NM1;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            if (cfg_fire) begin
                r_nm1 <= n_cfg_nm1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_west <= a_data[0].value;
        end
    end

    // chain A delays points by one row, chain B delays values by one more row
    for (genvar gi = 0; gi < MAX_WIDTH; gi++) begin : g_cell
        logic                    tail;
        fps_pkg::t_fps_point     a_next;
        logic signed [VAL_W-1:0] b_next;

        assign tail = (r_nm1 == CW'(gi));

        if (gi == MAX_WIDTH - 1) begin : g_end
            assign a_next = '0;
            assign b_next = '0;
        end else begin : g_mid
            assign a_next = a_data[gi+1];
            assign b_next = b_data[gi+1];
        end

        fps_cell #(.WIDTH(PW)) u_pt (
            .i_clk  (i_clk),
            .i_shift(shift),
            .i_tail (tail),
            .i_next (a_next),
            .i_head (in_pt),
            .o_data (a_data[gi])
        );

        fps_cell #(.WIDTH(VAL_W)) u_val (
            .i_clk  (i_clk),
            .i_shift(shift),
            .i_tail (tail),
            .i_next (b_next),
            .i_head (a_data[0].value),
            .o_data (b_data[gi])
        );
    end

    always_comb begin
        issue.valid    = (in_fire && r_row != '0) || flush_step;
        issue.west_en  = (r_col != '0);
        issue.east_en  = (r_col != r_nm1);
        issue.south_en = flushing ? (r_nm1 != '0) : (r_row != '0 && r_row != CW'(1));
        issue.north_en = !flushing;
        issue.last     = flushing && (r_col == r_nm1);

        ops.x     = a_data[0].value;
        ops.xw    = r_west;
        ops.xe    = a_data[1].value;
        ops.xs    = b_data[0];
        ops.xn    = i_in.sample_value;
        ops.diag  = a_data[0].diag;
        ops.west  = a_data[0].west;
        ops.east  = a_data[0].east;
        ops.south = a_data[0].south;
        ops.north = a_data[0].north;
    end

    fps_mac u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_issue(issue),
        .i_ops  (ops),
        .o_ready(mac_ready),
        .o_valid(res_valid),
        .o_res  (res),
        .i_ready(o_out.ready)
    );

    assign o_out.valid         = res_valid;
    assign o_out.product_value = res.value;
    assign o_out.saturated     = res.sat;
    assign o_out.frame_last    = res.last;

`ifndef NO_ASSERTIONS
    ap_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !cfg_fire && r_col == r_nm1 && r_row == r_nm1)
            |=> r_state == fps_pkg::ST_FLUSH)
        else $error("last point of frame did not start the drain");

    ap_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_nm1) && (r_row <= r_nm1))
        else $error("point counters beyond grid width");

    ap_drain_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fps_pkg::ST_FLUSH) |-> (r_row == '0 && !i_in.ready))
        else $error("drain with row count set or input open");
`endif

endmodule

`default_nettype wire
